FILE: rtl/aojq_pkg.sv
// ----------------------------------------------------------------------------
// aojq_pkg
// Shared types and codes for the arrival-ordered job queue.
// ----------------------------------------------------------------------------
`default_nettype none

package aojq_pkg;

    localparam int ARRIVAL_W   = 31;
    localparam int SERVICE_W   = 31;
    localparam int NAME_W      = 8;
    localparam int TAG_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int OCCUPANCY_W = 5;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [ARRIVAL_W-1:0] arrival;
        logic [SERVICE_W-1:0] service;
        logic [NAME_W-1:0]    name;
        logic [TAG_W-1:0]     tag;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_WR,
        ST_REM_RD,
        ST_REM_DAT,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/arrival_ordered_job_queue.sv
// ----------------------------------------------------------------------------
// arrival_ordered_job_queue
// Bounded job queue kept sorted by arrival time, earliest (and among equal
// times, oldest) first, held in a circular buffer in a single RAM.
// ----------------------------------------------------------------------------
//
//  channel  handshake                 word
//  -------  ------------------------  ---------------------------------------
//  in       i_in_valid / o_in_ready   kind, arrival, service, name, tag
//  out      o_out_valid / i_out_ready status, removed job, occupancy
//
//  Remove reads the head job (ST_REM_RD, ST_REM_DAT), then loads the result
//  register (ST_FIN). Insert walks from the tail, one RAM read and one
//  compare-and-shift per queued job it passes, then writes the new job
//  (ST_INS_WR); on an empty queue it goes straight to that write. A full
//  insert or an empty remove skips the RAM and goes straight to ST_FIN.
//  Reset (synchronous, active low) empties the queue; RAM contents are not
//  cleared. A stalled result holds in the output register; a new word is
//  taken meanwhile, and its result waits until the register frees.
//
`default_nettype none

module arrival_ordered_job_queue #(
    parameter int QUEUE_DEPTH = aojq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_kind,
    input  wire logic [aojq_pkg::ARRIVAL_W-1:0]      i_arrival_time,
    input  wire logic [aojq_pkg::SERVICE_W-1:0]      i_service_time,
    input  wire logic [aojq_pkg::NAME_W-1:0]         i_job_name,
    input  wire logic [aojq_pkg::TAG_W-1:0]          i_job_tag,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [aojq_pkg::STATUS_W-1:0]            o_status,
    output logic [aojq_pkg::ARRIVAL_W-1:0]           o_out_arrival,
    output logic [aojq_pkg::SERVICE_W-1:0]           o_out_service,
    output logic [aojq_pkg::NAME_W-1:0]              o_out_name,
    output logic [aojq_pkg::TAG_W-1:0]               o_out_tag,
    output logic [aojq_pkg::OCCUPANCY_W-1:0]         o_occupancy
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W:0]   SUM_WRAP = (PTR_W + 1)'(QUEUE_DEPTH);

    aojq_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  r_head,  n_head;
    logic [PTR_W-1:0]  r_pos,   n_pos;
    logic              r_kind;
    aojq_pkg::t_job    r_item;
    logic [aojq_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    aojq_pkg::t_job    r_res_job, n_res_job;
    logic              r_out_valid, n_out_valid;
    logic [aojq_pkg::STATUS_W-1:0] r_out_status;
    aojq_pkg::t_job    r_out_job;
    logic [aojq_pkg::OCCUPANCY_W-1:0] r_out_occ;

    logic              in_acc;
    logic              out_free;
    logic              later;
    logic [PTR_W-1:0]  log_idx;
    logic [PTR_W:0]    addr_sum;
    logic [PTR_W-1:0]  phys_addr;

    logic              ram_wr_en;
    aojq_pkg::t_job    ram_wr_data;
    logic              ram_rd_en;
    aojq_pkg::t_job    ram_rd_data;

    assign o_in_ready = (r_state == aojq_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // shared compare: queued job arrives strictly later than the new one
    assign later = ram_rd_data.arrival > r_item.arrival;

    // shared address unit: logical slot to physical RAM address
    always_comb begin
        unique case (r_state)
            aojq_pkg::ST_INS_RD:  log_idx = r_pos - PTR_W'(1);
            aojq_pkg::ST_INS_CMP: log_idx = r_pos;
            aojq_pkg::ST_INS_WR:  log_idx = r_pos;
            aojq_pkg::ST_REM_DAT: log_idx = PTR_W'(1);
            default:              log_idx = '0;
        endcase
    end

    assign addr_sum  = {1'b0, r_head} + {1'b0, log_idx};
    assign phys_addr = (addr_sum >= SUM_WRAP) ? PTR_W'(addr_sum - SUM_WRAP)
                                              : addr_sum[PTR_W-1:0];

    aojq_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (PTR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (phys_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (phys_addr),
        .o_rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aojq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_kind == aojq_pkg::KIND_INSERT) begin
                        if (r_count >= CNT_FULL) begin
                            n_state = aojq_pkg::ST_FIN;
                        end else if (r_count == '0) begin
                            n_state = aojq_pkg::ST_INS_WR;
                        end else begin
                            n_state = aojq_pkg::ST_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_state = aojq_pkg::ST_FIN;
                        end else begin
                            n_state = aojq_pkg::ST_REM_RD;
                        end
                    end
                end
            end
            aojq_pkg::ST_INS_RD:  n_state = aojq_pkg::ST_INS_CMP;
            aojq_pkg::ST_INS_CMP: begin
                if (later && (r_pos != PTR_W'(1))) begin
                    n_state = aojq_pkg::ST_INS_RD;
                end else begin
                    n_state = aojq_pkg::ST_INS_WR;
                end
            end
            aojq_pkg::ST_INS_WR:  n_state = aojq_pkg::ST_FIN;
            aojq_pkg::ST_REM_RD:  n_state = aojq_pkg::ST_REM_DAT;
            aojq_pkg::ST_REM_DAT: n_state = aojq_pkg::ST_FIN;
            aojq_pkg::ST_FIN: begin
                if (out_free) begin
                    n_state = aojq_pkg::ST_IDLE;
                end
            end
            default: n_state = aojq_pkg::ST_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        n_count      = r_count;
        n_head       = r_head;
        n_pos        = r_pos;
        n_res_status = r_res_status;
        n_res_job    = r_res_job;
        n_out_valid  = r_out_valid;
        ram_wr_en    = 1'b0;
        ram_wr_data  = r_item;
        ram_rd_en    = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            aojq_pkg::ST_IDLE: begin
                n_pos        = PTR_W'(r_count);
                n_res_job    = '0;
                n_res_status = aojq_pkg::STATUS_OK;
                if (i_kind == aojq_pkg::KIND_INSERT) begin
                    if (r_count >= CNT_FULL) begin
                        n_res_status = aojq_pkg::STATUS_FULL;
                    end
                end else if (r_count == '0) begin
                    n_res_status = aojq_pkg::STATUS_EMPTY;
                end
            end
            aojq_pkg::ST_INS_RD: begin
                ram_rd_en = 1'b1;
            end
            aojq_pkg::ST_INS_CMP: begin
                // shift the later job up one slot
                if (later) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data;
                    n_pos       = r_pos - PTR_W'(1);
                end
            end
            aojq_pkg::ST_INS_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = r_item;
                n_count     = r_count + CNT_W'(1);
            end
            aojq_pkg::ST_REM_RD: begin
                ram_rd_en = 1'b1;
            end
            aojq_pkg::ST_REM_DAT: begin
                n_res_job = ram_rd_data;
                n_head    = phys_addr;
                n_count   = r_count - CNT_W'(1);
            end
            aojq_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aojq_pkg::ST_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_res_status <= n_res_status;
        r_res_job    <= n_res_job;
        if (in_acc) begin
            r_kind         <= i_kind;
            r_item.arrival <= i_arrival_time;
            r_item.service <= i_service_time;
            r_item.name    <= i_job_name;
            r_item.tag     <= i_job_tag;
        end
        if ((r_state == aojq_pkg::ST_FIN) && out_free) begin
            r_out_status <= r_res_status;
            r_out_job    <= r_res_job;
            r_out_occ    <= aojq_pkg::OCCUPANCY_W'(r_count);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_arrival = r_out_job.arrival;
    assign o_out_service = r_out_job.service;
    assign o_out_name    = r_out_job.name;
    assign o_out_tag     = r_out_job.tag;
    assign o_occupancy   = r_out_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count beyond queue depth");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aojq_pkg::ST_IDLE) |-> !ram_wr_en)
        else $error("RAM write while idle");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aojq_pkg::ST_REM_DAT) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not decrement count");

    a_remove_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == aojq_pkg::ST_REM_RD) |-> (r_kind == aojq_pkg::KIND_REMOVE))
        else $error("remove path entered for an insert word");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && $past(i_rst_n)) |-> $past(r_state == aojq_pkg::ST_FIN))
        else $error("result loaded outside finish state");

endmodule

`default_nettype wire

FILE: rtl/aojq_ram.sv
// ----------------------------------------------------------------------------
// aojq_ram
// Job storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aojq_ram #(
    parameter int QUEUE_DEPTH = aojq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ADDR_W      = $clog2(QUEUE_DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire aojq_pkg::t_job    i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output aojq_pkg::t_job         o_rd_data
);

    aojq_pkg::t_job r_mem [QUEUE_DEPTH];
    aojq_pkg::t_job r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
